[rtl/sor_pkg.sv]
// ---------------------------------------------------------------------------
// sor_pkg: shared types and arithmetic for the periodic sor poisson solver
// Fixed-point helpers, register indexes and controller/datapath structs.
// ---------------------------------------------------------------------------
`default_nettype none
package sor_pkg;

    localparam int MAX_NODES = 64;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    localparam logic [3:0] REG_NODE_COUNT     = 4'd0;
    localparam logic [3:0] REG_DX_SQUARED     = 4'd1;
    localparam logic [3:0] REG_INV_DX_SQUARED = 4'd2;
    localparam logic [3:0] REG_INV_TWO_DX     = 4'd3;
    localparam logic [3:0] REG_RELAX_FACTOR   = 4'd4;
    localparam logic [3:0] REG_RESIDUAL_LIMIT = 4'd5;
    localparam logic [3:0] REG_MAX_ITERATIONS = 4'd6;
    localparam logic [3:0] REG_CHECK_INTERVAL = 4'd7;

    typedef enum logic [2:0] {
        KIND_END,
        KIND_RELAX,
        KIND_AVG,
        KIND_FIELD,
        KIND_RES
    } t_kind;

    typedef struct packed {
        logic [6:0]  node_count;
        logic [31:0] dx_squared;
        logic [31:0] inv_dx_squared;
        logic [31:0] inv_two_dx;
        logic [17:0] relax_factor;
        logic [62:0] residual_limit;
        logic [15:0] max_iterations;
        logic [9:0]  check_interval;
    } t_cfg;

    typedef struct packed {
        logic             load_we;
        logic [IDX_W-1:0] load_addr;
        logic [IDX_W-1:0] raddr_p;
        logic [IDX_W-1:0] raddr_b;
        logic             cap_l;
        logic             cap_c;
        logic             cap_r;
        t_kind            kind;
        logic             p_we;
        logic             p_zero;
        logic [IDX_W-1:0] p_waddr;
        logic             acc_clr;
        logic             acc_en;
        logic             out_load;
        logic [IDX_W-1:0] out_index;
        logic             out_last;
        logic             out_conv;
    } t_cmd;

    typedef struct packed {
        logic out_full;
        logic below_limit;
    } t_stat;

    // round half up after dropping the fraction bits
    function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] v);
        logic signed [63:0] f;
        f = v >>> FRAC_BITS;
        return f + $signed({63'd0, v[FRAC_BITS-1]});
    endfunction

    function automatic logic signed [63:0] rnd_half(input logic signed [63:0] v);
        logic signed [63:0] f;
        f = v >>> 1;
        return f + $signed({63'd0, v[0]});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/sor_cfg.sv]
// ---------------------------------------------------------------------------
// sor_cfg: configuration register file
// Holds the solver registers, written through the configuration channel.
// ---------------------------------------------------------------------------
`default_nettype none
module sor_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [3:0]    i_cfg_index,
    input  wire logic [63:0]   i_cfg_data,
    output sor_pkg::t_cfg      o_cfg
);

    sor_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_count     <= 7'd64;
            r_cfg.dx_squared     <= 32'd655;
            r_cfg.inv_dx_squared <= 32'd6553600;
            r_cfg.inv_two_dx     <= 32'd327680;
            r_cfg.relax_factor   <= 18'd91750;
            r_cfg.residual_limit <= 63'd274878;
            r_cfg.max_iterations <= 16'd10000;
            r_cfg.check_interval <= 10'd50;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sor_pkg::REG_NODE_COUNT:     r_cfg.node_count     <= i_cfg_data[6:0];
                sor_pkg::REG_DX_SQUARED:     r_cfg.dx_squared     <= i_cfg_data[31:0];
                sor_pkg::REG_INV_DX_SQUARED: r_cfg.inv_dx_squared <= i_cfg_data[31:0];
                sor_pkg::REG_INV_TWO_DX:     r_cfg.inv_two_dx     <= i_cfg_data[31:0];
                sor_pkg::REG_RELAX_FACTOR:   r_cfg.relax_factor   <= i_cfg_data[17:0];
                sor_pkg::REG_RESIDUAL_LIMIT: r_cfg.residual_limit <= i_cfg_data[62:0];
                sor_pkg::REG_MAX_ITERATIONS: r_cfg.max_iterations <= i_cfg_data[15:0];
                sor_pkg::REG_CHECK_INTERVAL: r_cfg.check_interval <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/sor_datapath.sv]
// ---------------------------------------------------------------------------
// sor_datapath: stores and arithmetic pipeline
// Right-hand-side and potential memories, operand registers, a four-stage
// arithmetic pipeline, residual accumulator and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
module sor_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  sor_pkg::t_cfg      i_cfg,
    input  sor_pkg::t_cmd      i_cmd,
    output sor_pkg::t_stat     o_stat,
    input  wire logic [31:0]   i_rhs,
    output logic               o_m_valid,
    input  wire logic          i_m_ready,
    output logic [71:0]        o_m_data,
    output logic               o_m_conv,
    output logic               o_m_last
);

    logic signed [31:0] rhs_mem [sor_pkg::MAX_NODES];
    logic signed [31:0] pot_mem [sor_pkg::MAX_NODES];

    logic signed [31:0] r_bq, r_pq;
    logic signed [31:0] r_op_l, r_op_c, r_op_r, r_op_b;

    logic signed [63:0] r_bsc;
    logic signed [34:0] r_lap;
    logic signed [32:0] r_dlr, r_sum;
    logic signed [31:0] r_g;
    logic signed [63:0] r_sp;
    logic signed [51:0] r_rp;
    logic [31:0]        r_m;
    logic signed [31:0] r_e;
    logic signed [31:0] r_newp;
    logic [63:0]        r_sq;
    logic [63:0]        r_acc;

    logic               r_out_valid;
    logic [71:0]        r_out_data;
    logic               r_out_conv, r_out_last;

    logic signed [63:0] n_bsc;
    logic signed [34:0] n_lap;
    logic signed [34:0] mul_a;
    logic [31:0]        mul_b;
    logic [34:0]        mag_a;
    logic [66:0]        mag_p;
    logic [62:0]        mag_s;
    logic signed [63:0] n_sp;
    logic signed [63:0] g_arg;
    logic signed [32:0] g_diff;
    logic signed [63:0] rs;
    logic signed [63:0] dres;
    logic [63:0]        dmag;
    logic [31:0]        n_m;
    logic signed [63:0] n_newp_sum;
    logic [64:0]        acc_sum;

    // memories with registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            rhs_mem[i_cmd.load_addr] <= i_rhs;
        end
        r_bq <= rhs_mem[i_cmd.raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.p_we) begin
            pot_mem[i_cmd.p_waddr] <= i_cmd.p_zero ? 32'sd0 : r_newp;
        end
        r_pq <= pot_mem[i_cmd.raddr_p];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_l) begin
            r_op_l <= r_pq;
        end
        if (i_cmd.cap_c) begin
            r_op_c <= r_pq;
            r_op_b <= r_bq;
        end
        if (i_cmd.cap_r) begin
            r_op_r <= r_pq;
        end
    end

    // stage 1: scaled rhs and neighbor combinations
    assign n_bsc = sor_pkg::rnd_frac($signed(64'(r_op_b)) * $signed({32'd0, i_cfg.dx_squared}));
    assign n_lap = 35'(r_op_l) - (35'(r_op_c) <<< 1) + 35'(r_op_r);

    // stage 2: shared signed by unsigned multiply with saturation, and the average
    assign mul_a = (i_cmd.kind == sor_pkg::KIND_FIELD) ? 35'(r_dlr) : r_lap;
    assign mul_b = (i_cmd.kind == sor_pkg::KIND_FIELD) ? i_cfg.inv_two_dx
                                                       : i_cfg.inv_dx_squared;
    assign mag_a = mul_a[34] ? 35'(-mul_a) : 35'(mul_a);
    assign mag_p = 67'(mag_a) * 67'(mul_b);
    assign mag_s = (mag_p > 67'h7FFFFFFFFFFFFFFF) ? 63'h7FFFFFFFFFFFFFFF : mag_p[62:0];
    assign n_sp  = mul_a[34] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
    assign g_arg = 64'(r_sum) - ((i_cmd.kind == sor_pkg::KIND_AVG) ? 64'sd0 : r_bsc);

    // stage 3: relaxation product, residual magnitude, field
    assign g_diff = 33'(r_g) - 33'(r_op_c);
    assign rs     = sor_pkg::rnd_frac(r_sp);
    assign dres   = rs - 64'(r_op_b);
    assign dmag   = dres[63] ? 64'(-dres) : 64'(dres);
    assign n_m    = (dmag > 64'h00000000FFFFFFFF) ? 32'hFFFFFFFF : dmag[31:0];

    // stage 4: new potential
    assign n_newp_sum = 64'(r_op_c) + sor_pkg::rnd_frac(64'(r_rp));

    always_ff @(posedge i_clk) begin
        r_bsc  <= n_bsc;
        r_lap  <= n_lap;
        r_dlr  <= 33'(r_op_l) - 33'(r_op_r);
        r_sum  <= 33'(r_op_l) + 33'(r_op_r);
        r_sp   <= n_sp;
        r_g    <= sor_pkg::sat32(sor_pkg::rnd_half(g_arg));
        r_rp   <= $signed({1'b0, i_cfg.relax_factor}) * g_diff;
        r_m    <= n_m;
        r_e    <= sor_pkg::sat32(rs);
        r_newp <= (i_cmd.kind == sor_pkg::KIND_RELAX) ? sor_pkg::sat32(n_newp_sum) : r_g;
        r_sq   <= 64'(r_m) * 64'(r_m);
    end

    assign acc_sum = {1'b0, r_acc} + {1'b0, r_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= acc_sum[64] ? 64'hFFFFFFFFFFFFFFFF : acc_sum[63:0];
        end
    end

    // result register, parts the solver from the output stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {2'b00, r_e, r_op_c, i_cmd.out_index};
            r_out_conv <= i_cmd.out_conv;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_m_valid          = r_out_valid;
    assign o_m_data           = r_out_data;
    assign o_m_conv           = r_out_conv;
    assign o_m_last           = r_out_last;
    assign o_stat.out_full    = r_out_valid;
    assign o_stat.below_limit = (r_acc < {1'b0, i_cfg.residual_limit});

endmodule
`default_nettype wire

[rtl/sor_ctrl.sv]
// ---------------------------------------------------------------------------
// sor_ctrl: solver sequencer
// Loads values, clears the potentials, runs sweeps and residual checks,
// averages the ends and walks the results out.
// ---------------------------------------------------------------------------
`default_nettype none
module sor_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  sor_pkg::t_cfg      i_cfg,
    input  sor_pkg::t_stat     i_stat,
    input  wire logic          i_s_valid,
    input  wire logic          i_s_last,
    output logic               o_s_ready,
    output sor_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SWEEP,
        ST_RES,
        ST_CMP,
        ST_AVG,
        ST_OUT
    } t_state;

    localparam logic [3:0] STEP_LAST = 4'd8;

    t_state                      r_state;
    logic [3:0]                  r_step;
    logic [sor_pkg::IDX_W-1:0]   r_k;
    logic [sor_pkg::CNT_W-1:0]   r_load;
    logic [15:0]                 r_sweep;
    logic [9:0]                  r_chk;
    logic                        r_conv;

    logic [sor_pkg::CNT_W-1:0]   n_nodes;
    logic [sor_pkg::IDX_W-1:0]   k_last, k_pen;
    logic [9:0]                  ci_last;
    logic [sor_pkg::IDX_W-1:0]   a_l, a_c, a_r, a_b;
    logic                        s_acc;
    logic                        op_done;
    logic [16:0]                 sweep_inc;

    always_comb begin
        if (i_cfg.node_count < 7'd4) begin
            n_nodes = 7'd4;
        end else if (i_cfg.node_count > 7'(sor_pkg::MAX_NODES)) begin
            n_nodes = 7'(sor_pkg::MAX_NODES);
        end else begin
            n_nodes = i_cfg.node_count;
        end
    end

    assign k_last    = sor_pkg::IDX_W'(n_nodes - 7'd1);
    assign k_pen     = sor_pkg::IDX_W'(n_nodes - 7'd2);
    assign ci_last   = (i_cfg.check_interval == 10'd0) ? 10'd0 : i_cfg.check_interval - 10'd1;
    assign s_acc     = i_s_valid && (r_state == ST_LOAD);
    assign o_s_ready = (r_state == ST_LOAD);
    assign op_done   = (r_step == STEP_LAST);
    assign sweep_inc = 17'(r_sweep) + 17'd1;

    // operand addresses of the current node operation
    always_comb begin
        a_l = r_k - 1'b1;
        a_c = r_k;
        a_r = r_k + 1'b1;
        a_b = r_k;
        case (r_state)
            ST_SWEEP, ST_OUT: begin
                if (r_k == '0 || r_k == k_last) begin
                    a_l = k_pen;
                    a_r = sor_pkg::IDX_W'(1);
                end
            end
            ST_RES: begin
                if (r_k == k_pen) begin
                    a_l = k_pen;
                    a_c = '0;
                    a_r = sor_pkg::IDX_W'(1);
                    a_b = '0;
                end else if (r_k == k_last) begin
                    a_l = k_pen;
                    a_r = sor_pkg::IDX_W'(1);
                end else begin
                    a_l = r_k;
                    a_c = r_k + 1'b1;
                    a_r = r_k + 2'd2;
                    a_b = r_k + 1'b1;
                end
            end
            ST_AVG: begin
                a_l = '0;
                a_r = k_last;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.kind      = sor_pkg::KIND_END;
        o_cmd.load_we   = s_acc && (r_load < 7'(sor_pkg::MAX_NODES));
        o_cmd.load_addr = r_load[sor_pkg::IDX_W-1:0];
        o_cmd.raddr_p   = (r_step == 4'd0) ? a_l : ((r_step == 4'd1) ? a_c : a_r);
        o_cmd.raddr_b   = a_b;
        o_cmd.cap_l     = (r_step == 4'd1);
        o_cmd.cap_c     = (r_step == 4'd2);
        o_cmd.cap_r     = (r_step == 4'd3);
        o_cmd.p_waddr   = r_k;
        o_cmd.out_index = r_k;
        o_cmd.out_last  = (r_k == k_last);
        o_cmd.out_conv  = r_conv;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.p_we   = 1'b1;
                o_cmd.p_zero = 1'b1;
            end
            ST_SWEEP: begin
                o_cmd.kind = (r_k == '0 || r_k == k_last) ? sor_pkg::KIND_END
                                                          : sor_pkg::KIND_RELAX;
                o_cmd.p_we = op_done;
            end
            ST_RES: begin
                o_cmd.kind    = sor_pkg::KIND_RES;
                o_cmd.acc_clr = (r_k == '0) && (r_step == 4'd0);
                o_cmd.acc_en  = op_done;
            end
            ST_AVG: begin
                o_cmd.kind    = sor_pkg::KIND_AVG;
                o_cmd.p_we    = (r_step >= STEP_LAST);
                o_cmd.p_waddr = op_done ? '0 : k_last;
            end
            ST_OUT: begin
                o_cmd.kind     = sor_pkg::KIND_FIELD;
                o_cmd.out_load = op_done && !i_stat.out_full;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_step  <= '0;
            r_k     <= '0;
            r_load  <= '0;
            r_sweep <= '0;
            r_chk   <= '0;
            r_conv  <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (s_acc) begin
                        if (r_load < 7'(sor_pkg::MAX_NODES)) begin
                            r_load <= r_load + 1'b1;
                        end
                        if (i_s_last) begin
                            r_state <= ST_CLEAR;
                            r_k     <= '0;
                            r_conv  <= 1'b0;
                        end
                    end
                end
                ST_CLEAR: begin
                    r_step <= '0;
                    if (r_k == k_last) begin
                        r_k     <= '0;
                        r_sweep <= '0;
                        r_chk   <= '0;
                        r_state <= (i_cfg.max_iterations == 16'd0) ? ST_AVG : ST_SWEEP;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_SWEEP, ST_RES: begin
                    if (op_done) begin
                        r_step <= '0;
                        if (r_k == k_last) begin
                            r_k <= '0;
                            if (r_state == ST_RES) begin
                                r_state <= ST_CMP;
                            end else if (r_chk == 10'd0) begin
                                r_state <= ST_RES;
                            end else begin
                                r_chk <= (r_chk == ci_last) ? 10'd0 : r_chk + 1'b1;
                                if (sweep_inc < 17'(i_cfg.max_iterations)) begin
                                    r_sweep <= sweep_inc[15:0];
                                end else begin
                                    r_state <= ST_AVG;
                                end
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_CMP: begin
                    r_step <= '0;
                    r_k    <= '0;
                    if (i_stat.below_limit) begin
                        r_conv  <= 1'b1;
                        r_state <= ST_AVG;
                    end else begin
                        r_chk <= (r_chk == ci_last) ? 10'd0 : r_chk + 1'b1;
                        if (sweep_inc < 17'(i_cfg.max_iterations)) begin
                            r_sweep <= sweep_inc[15:0];
                            r_state <= ST_SWEEP;
                        end else begin
                            r_state <= ST_AVG;
                        end
                    end
                end
                ST_AVG: begin
                    if (r_step > STEP_LAST) begin
                        r_step  <= '0;
                        r_k     <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (op_done) begin
                        if (!i_stat.out_full) begin
                            r_step <= '0;
                            if (r_k == k_last) begin
                                r_k     <= '0;
                                r_load  <= '0;
                                r_state <= ST_LOAD;
                            end else begin
                                r_k <= r_k + 1'b1;
                            end
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_LAST + 4'd1)
        else $error("step counter out of range");
    a_node_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> (7'(r_k) < n_nodes))
        else $error("node index beyond node count");
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_sweep < i_cfg.max_iterations))
        else $error("sweep beyond max iterations");
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_stat.out_full)
        else $error("result loaded over a pending transaction");
`endif

endmodule
`default_nettype wire

[rtl/periodic_poisson_sor_solver.sv]
// ---------------------------------------------------------------------------
// periodic_poisson_sor_solver: 1-d periodic poisson solver, over-relaxation
// Loads right-hand-side values, solves on the last one, then streams out
// potential, field and converged flag for each node.
// ---------------------------------------------------------------------------
//  channel   direction  transaction
//  s_axis    in         one rhs value; tlast starts the solve
//  m_axis    out        one node result; tlast on the final node
//  cfg       in         one register write (index, data)
//
//  loading takes one value per cycle.
//  a solve holds s_axis off: a clear pass over the nodes, then node operations
//  through the potential memory read port and the four-stage pipeline,
//  node_count ops per sweep plus node_count per residual check and a
//  compare, then the end average and the results, one node at a time.
//  reset is synchronous; the rhs memory is not cleared.
//  a stalled m_axis holds the result register and pauses the sequencer.
`default_nettype none
module periodic_poisson_sor_solver (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [31:0]   s_axis_tdata,   // [31:0] rhs_value
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [71:0]        m_axis_tdata,   // [5:0] node_index, [37:6] potential,
                                               // [69:38] electric_field, zero pad
    output logic [0:0]         m_axis_tuser,   // [0] converged
    output logic               m_axis_tlast,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [3:0]    i_cfg_index,
    input  wire logic [63:0]   i_cfg_data
);

    sor_pkg::t_cfg  cfg;
    sor_pkg::t_cmd  cmd;
    sor_pkg::t_stat stat;
    logic           conv;

    sor_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sor_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_stat    (stat),
        .i_s_valid (s_axis_tvalid),
        .i_s_last  (s_axis_tlast),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    sor_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_rhs     (s_axis_tdata),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata),
        .o_m_conv  (conv),
        .o_m_last  (m_axis_tlast)
    );

    assign m_axis_tuser = conv;

endmodule
`default_nettype wire
